// ----- hw/rtl/swi_pmw_pkg.sv -----
// ============================================================================
// swi_pmw_pkg
// Types, register indexes and the sigmoid lookup table for the phase mask
// weighting pipeline.
// ============================================================================
package swi_pmw_pkg;

    localparam int SIG_SIZE = 1024;
    localparam int SIG_HALF = SIG_SIZE / 2;
    localparam int SIG_IDX_W = $clog2(SIG_SIZE);
    localparam int MAX_POWER = 8;
    localparam logic [15:0] ONE_Q15 = 16'd32768;
    localparam logic [63:0] EXP_STEP_Q32 = 64'd4228380001;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_MASK_MODE = 3'd0;
    localparam logic [2:0] REG_LEFT_CUTOFF = 3'd1;
    localparam logic [2:0] REG_RIGHT_CUTOFF = 3'd2;
    localparam logic [2:0] REG_POWER_COUNT = 3'd3;
    localparam logic [2:0] REG_SIG_GAIN = 3'd4;
    localparam logic [2:0] REG_SIG_OFFSET = 3'd5;

    // Mask mode codes.
    localparam logic [2:0] MODE_NEGATIVE = 3'd0;
    localparam logic [2:0] MODE_POSITIVE = 3'd1;
    localparam logic [2:0] MODE_SYMMETRIC = 3'd2;
    localparam logic [2:0] MODE_ASYMMETRIC = 3'd3;
    localparam logic [2:0] MODE_SIGMOID = 3'd4;

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_ONE,
        KIND_RAMP,
        KIND_SIG
    } kind_t;

    typedef logic [SIG_SIZE-1:0][15:0] sig_tab_t;

    // Logistic curve in Q1.15, built from a rounded exponential recurrence.
    function automatic sig_tab_t build_sig_tab();
        sig_tab_t tab;
        logic [SIG_HALF:0][15:0] pos;
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] quo;
        e = 64'd1 << 32;
        for (int k = 0; k <= SIG_HALF; k++) begin
            d = (64'd1 << 32) + e;
            num = (64'd1 << 47) + (d >> 1);
            // Long division of the rounded numerator; the quotient fits 16 bits.
            rem = '0;
            quo = '0;
            for (int b = 47; b >= 0; b--) begin
                rem = {rem[62:0], num[b]};
                quo = {quo[62:0], 1'b0};
                if (rem >= d) begin
                    rem = rem - d;
                    quo[0] = 1'b1;
                end
            end
            pos[k] = quo[15:0];
            e = (e * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
        end
        for (int i = 0; i < SIG_SIZE; i++) begin
            if (i >= SIG_HALF) begin
                tab[i] = pos[i - SIG_HALF];
            end else begin
                tab[i] = ONE_Q15 - pos[SIG_HALF - i];
            end
        end
        return tab;
    endfunction

    localparam sig_tab_t SIG_TAB = build_sig_tab();

    // One pipeline slot; each stage uses the fields it needs.
    typedef struct packed {
        logic vld;
        logic [15:0] mag;
        kind_t kind;
        logic [15:0] ac;
        logic [16:0] rem;
        logic [15:0] quo;
        logic signed [16:0] diff;
        logic signed [32:0] prod;
        logic [SIG_IDX_W-1:0] idx;
        logic [15:0] sig;
        logic [15:0] mask;
        logic [15:0] acc;
        logic [3:0] pwr;
        logic [15:0] wval;
    } item_t;

endpackage

// ----- hw/rtl/swi_phase_mask_weight_top.sv -----
// ============================================================================
// swi_phase_mask_weight_top
// Phase mask weighting of magnitude voxels: ramp or sigmoid mask, powered,
// then applied to the magnitude.
// ============================================================================
// The block accepts one voxel per clock and returns one result per voxel,
// in order. The length of the pipeline is set by the 16-stage restoring
// divider that forms the ramp quotient (one quotient bit per stage) and
// by the eight multiply stages that raise the mask to its power. The
// whole pipeline holds while the output waits for m_tready.
// Configuration registers must be written only while the pipeline is empty.
module swi_phase_mask_weight_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] magnitude, [31:16] phase
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [15:0] weighted_value, [31:16] mask_value
);

    localparam int DivFirst = 1;
    localparam int DivSteps = 16;
    localparam int StProd = 1;
    localparam int StIdx = 2;
    localparam int StRom = 3;
    localparam int StMask = DivFirst + DivSteps;
    localparam int PowFirst = StMask + 1;
    localparam int StOut = PowFirst + swi_pmw_pkg::MAX_POWER;
    localparam int NumStages = StOut + 1;

    logic [2:0]         mask_mode_reg;
    logic signed [15:0] left_cutoff_reg;
    logic signed [15:0] right_cutoff_reg;
    logic [3:0]         power_count_reg;
    logic signed [15:0] sig_gain_reg;
    logic signed [15:0] sig_offset_reg;

    swi_pmw_pkg::item_t pipe_reg  [NumStages];
    swi_pmw_pkg::item_t pipe_next [NumStages];
    swi_pmw_pkg::item_t entry_item;
    logic [15:0]        rom_data_reg;
    logic               adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_mode_reg    <= swi_pmw_pkg::MODE_NEGATIVE;
            left_cutoff_reg  <= -16'sd32768;
            right_cutoff_reg <= 16'sd32767;
            power_count_reg  <= 4'd4;
            sig_gain_reg     <= 16'sd256;
            sig_offset_reg   <= 16'sd0;
        end else if (cfg_we) begin
            case (cfg_index)
                swi_pmw_pkg::REG_MASK_MODE:    mask_mode_reg    <= cfg_wdata[2:0];
                swi_pmw_pkg::REG_LEFT_CUTOFF:  left_cutoff_reg  <= $signed(cfg_wdata);
                swi_pmw_pkg::REG_RIGHT_CUTOFF: right_cutoff_reg <= $signed(cfg_wdata);
                swi_pmw_pkg::REG_POWER_COUNT:  power_count_reg  <= cfg_wdata[3:0];
                swi_pmw_pkg::REG_SIG_GAIN:     sig_gain_reg     <= $signed(cfg_wdata);
                swi_pmw_pkg::REG_SIG_OFFSET:   sig_offset_reg   <= $signed(cfg_wdata);
                default: ;
            endcase
        end
    end

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign m_tvalid = pipe_reg[StOut].vld;
    assign m_tdata  = {pipe_reg[StOut].mask, pipe_reg[StOut].wval};

    // Entry stage: classify the phase against the cutoffs.
    always_comb begin
        logic signed [15:0] p;
        logic [15:0] ap;
        logic [15:0] al;
        logic [15:0] ar;
        swi_pmw_pkg::item_t it;
        p  = $signed(s_tdata[31:16]);
        ap = p[15] ? (~s_tdata[31:16] + 16'd1) : s_tdata[31:16];
        al = left_cutoff_reg[15] ? (~left_cutoff_reg + 16'd1) : left_cutoff_reg;
        ar = right_cutoff_reg[15] ? (~right_cutoff_reg + 16'd1) : right_cutoff_reg;
        it      = '0;
        it.vld  = s_tvalid;
        it.mag  = s_tdata[15:0];
        it.kind = swi_pmw_pkg::KIND_ZERO;
        it.rem  = {1'b0, ap};
        it.ac   = ar;
        it.diff = {p[15], p} - {sig_offset_reg[15], sig_offset_reg};
        it.pwr  = (power_count_reg > 4'(swi_pmw_pkg::MAX_POWER))
                  ? 4'(swi_pmw_pkg::MAX_POWER) : power_count_reg;
        case (mask_mode_reg)
            swi_pmw_pkg::MODE_NEGATIVE: begin
                it.ac = al;
                if (p > 16'sd0) begin
                    it.kind = swi_pmw_pkg::KIND_ONE;
                end else if (p <= left_cutoff_reg) begin
                    it.kind = swi_pmw_pkg::KIND_ZERO;
                end else begin
                    it.kind = swi_pmw_pkg::KIND_RAMP;
                end
            end
            swi_pmw_pkg::MODE_POSITIVE: begin
                if (p < 16'sd0) begin
                    it.kind = swi_pmw_pkg::KIND_ONE;
                end else if (p >= right_cutoff_reg) begin
                    it.kind = swi_pmw_pkg::KIND_ZERO;
                end else begin
                    it.kind = swi_pmw_pkg::KIND_RAMP;
                end
            end
            swi_pmw_pkg::MODE_SYMMETRIC, swi_pmw_pkg::MODE_ASYMMETRIC: begin
                if (p < left_cutoff_reg) begin
                    it.kind = swi_pmw_pkg::KIND_ZERO;
                end else if (p >= right_cutoff_reg) begin
                    it.kind = (mask_mode_reg == swi_pmw_pkg::MODE_ASYMMETRIC)
                              ? swi_pmw_pkg::KIND_ONE : swi_pmw_pkg::KIND_ZERO;
                end else begin
                    it.kind = swi_pmw_pkg::KIND_RAMP;
                    if (p < 16'sd0) begin
                        it.ac = al;
                    end
                end
            end
            swi_pmw_pkg::MODE_SIGMOID: begin
                if (p < left_cutoff_reg) begin
                    it.kind = swi_pmw_pkg::KIND_ZERO;
                end else if (p >= right_cutoff_reg) begin
                    it.kind = swi_pmw_pkg::KIND_ONE;
                end else begin
                    it.kind = swi_pmw_pkg::KIND_SIG;
                end
            end
            default: begin
                // Unused mode codes give a zero mask and a zero weighted value.
                it.kind = swi_pmw_pkg::KIND_ZERO;
                it.mag  = 16'd0;
            end
        endcase
        entry_item = it;
    end

    always_comb begin
        logic [16:0] r;
        logic signed [18:0] xs;
        r  = '0;
        xs = '0;
        pipe_next[0] = entry_item;
        for (int i = 1; i < NumStages; i++) begin
            pipe_next[i] = pipe_reg[i-1];
            // Restoring divider: one quotient bit of (|p| << 15) / |cutoff| per stage.
            if (i >= DivFirst && i < DivFirst + DivSteps) begin
                r = pipe_reg[i-1].rem;
                if (i != DivFirst) begin
                    r = {r[15:0], 1'b0};
                end
                if (r >= {1'b0, pipe_reg[i-1].ac}) begin
                    r = r - {1'b0, pipe_reg[i-1].ac};
                    pipe_next[i].quo = {pipe_reg[i-1].quo[14:0], 1'b1};
                end else begin
                    pipe_next[i].quo = {pipe_reg[i-1].quo[14:0], 1'b0};
                end
                pipe_next[i].rem = r;
            end
            if (i == StProd) begin
                pipe_next[i].prod = sig_gain_reg * pipe_reg[i-1].diff;
            end
            if (i == StIdx) begin
                // Arithmetic shift floors the product to steps of 1/64.
                xs = pipe_reg[i-1].prod[32:14];
                if (xs < -19'sd512) begin
                    pipe_next[i].idx = '0;
                end else if (xs > 19'sd511) begin
                    pipe_next[i].idx = '1;
                end else begin
                    pipe_next[i].idx = {~xs[9], xs[8:0]};
                end
            end
            if (i == StRom + 1) begin
                pipe_next[i].sig = rom_data_reg;
            end
            if (i == StMask) begin
                pipe_next[i].acc = swi_pmw_pkg::ONE_Q15;
                case (pipe_reg[i-1].kind)
                    swi_pmw_pkg::KIND_ZERO: pipe_next[i].mask = 16'd0;
                    swi_pmw_pkg::KIND_ONE:  pipe_next[i].mask = swi_pmw_pkg::ONE_Q15;
                    swi_pmw_pkg::KIND_RAMP: begin
                        if (pipe_reg[i-1].quo > swi_pmw_pkg::ONE_Q15) begin
                            pipe_next[i].mask = 16'd0;
                        end else begin
                            pipe_next[i].mask = swi_pmw_pkg::ONE_Q15 - pipe_reg[i-1].quo;
                        end
                    end
                    swi_pmw_pkg::KIND_SIG:  pipe_next[i].mask = pipe_reg[i-1].sig;
                    default:                pipe_next[i].mask = 16'd0;
                endcase
            end
            if (i >= PowFirst && i < StOut) begin
                if (4'(i - PowFirst) < pipe_reg[i-1].pwr) begin
                    pipe_next[i].acc = 16'((32'(pipe_reg[i-1].acc)
                                           * 32'(pipe_reg[i-1].mask)) >> 15);
                end
            end
            if (i == StOut) begin
                pipe_next[i].wval = 16'((32'(pipe_reg[i-1].mag)
                                        * 32'(pipe_reg[i-1].acc)) >> 15);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NumStages; i++) begin
                pipe_reg[i].vld <= 1'b0;
            end
        end else if (adv) begin
            for (int i = 0; i < NumStages; i++) begin
                pipe_reg[i] <= pipe_next[i];
            end
        end
    end

    // Registered table read, aligned with the item in the ROM stage.
    always_ff @(posedge aclk) begin
        if (adv) begin
            rom_data_reg <= swi_pmw_pkg::SIG_TAB[pipe_reg[StIdx].idx];
        end
    end

    a_ramp_quotient_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_reg[StMask-1].vld && pipe_reg[StMask-1].kind == swi_pmw_pkg::KIND_RAMP
        && pipe_reg[StMask-1].ac != 16'd0 |-> pipe_reg[StMask-1].quo <= swi_pmw_pkg::ONE_Q15)
        else $error("ramp quotient above one");

    a_power_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_reg[StOut-1].vld |-> pipe_reg[StOut-1].acc <= swi_pmw_pkg::ONE_Q15)
        else $error("powered mask above one");

    a_mask_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:16] <= swi_pmw_pkg::ONE_Q15)
        else $error("mask above one");

    a_weight_not_above_mag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:0] <= pipe_reg[StOut].mag)
        else $error("weighted value exceeds magnitude");

endmodule

// ----- bench/swi_pmw_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// swi_pmw_checker
// Watches both streams of the phase mask weighting block, predicts each
// result from the accepted voxel and the current register settings, and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module swi_pmw_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    output int          fail_count,
    output int          pending_count
);

    logic [2:0]         mode_r;
    logic signed [15:0] left_r;
    logic signed [15:0] right_r;
    logic [3:0]         power_r;
    logic signed [15:0] gain_r;
    logic signed [15:0] offset_r;

    logic [15:0] logistic [swi_pmw_pkg::SIG_SIZE];
    // Expected results in request order, kept in a ring.
    logic [31:0] expected_results [4096];
    int          wr_count;
    int          rd_count;

    initial begin : build_logistic
        logic [63:0] e;
        logic [63:0] d;
        logic [15:0] half_curve [swi_pmw_pkg::SIG_HALF+1];
        e = 64'd1 << 32;
        for (int k = 0; k <= swi_pmw_pkg::SIG_HALF; k++) begin
            d = (64'd1 << 32) + e;
            half_curve[k] = 16'(((64'd1 << 47) + (d >> 1)) / d);
            e = (e * 64'd4228380001 + (64'd1 << 31)) >> 32;
        end
        for (int i = 0; i < swi_pmw_pkg::SIG_SIZE; i++)
            logistic[i] = (i >= swi_pmw_pkg::SIG_HALF)
                          ? half_curve[i - swi_pmw_pkg::SIG_HALF]
                          : 16'(32768 - half_curve[swi_pmw_pkg::SIG_HALF - i]);
    end

    function automatic logic [15:0] ramp_mask(longint ap, longint ac);
        longint q;
        if (ac == 0) return 16'd0;
        q = (ap << 15) / ac;
        if (q > 32768) q = 32768;
        return 16'(32768 - q);
    endfunction

    function automatic logic [15:0] logistic_mask(longint p);
        longint prod;
        longint x;
        prod = longint'(gain_r) * (p - longint'(offset_r));
        if (prod >= 0) x = prod >>> 14;
        else x = -((-prod + 16383) >>> 14);
        if (x < -swi_pmw_pkg::SIG_HALF) x = -swi_pmw_pkg::SIG_HALF;
        if (x > swi_pmw_pkg::SIG_HALF - 1) x = swi_pmw_pkg::SIG_HALF - 1;
        return logistic[x + swi_pmw_pkg::SIG_HALF];
    endfunction

    function automatic logic [31:0] weigh_voxel(logic [31:0] voxel);
        longint mag;
        longint p;
        longint lc;
        longint rc;
        longint m;
        longint acc;
        int n;
        mag = voxel[15:0];
        p = longint'($signed(voxel[31:16]));
        lc = left_r;
        rc = right_r;
        m = 0;
        acc = 32768;
        case (mode_r)
            swi_pmw_pkg::MODE_NEGATIVE:
                m = (p > 0) ? 32768 : (p <= lc) ? 0 : ramp_mask(-p, -lc);
            swi_pmw_pkg::MODE_POSITIVE:
                m = (p < 0) ? 32768 : (p >= rc) ? 0 : ramp_mask(p, rc);
            swi_pmw_pkg::MODE_SYMMETRIC, swi_pmw_pkg::MODE_ASYMMETRIC: begin
                if (p < lc) m = 0;
                else if (p >= rc) m = (mode_r == swi_pmw_pkg::MODE_ASYMMETRIC) ? 32768 : 0;
                else if (p >= 0) m = ramp_mask(p, rc);
                else m = ramp_mask(-p, (lc < 0) ? -lc : lc);
            end
            swi_pmw_pkg::MODE_SIGMOID:
                m = (p < lc) ? 0 : (p >= rc) ? 32768 : logistic_mask(p);
            default: return 32'd0;
        endcase
        n = (power_r > swi_pmw_pkg::MAX_POWER) ? swi_pmw_pkg::MAX_POWER : power_r;
        for (int t = 0; t < n; t++) acc = (acc * m) >> 15;
        return {16'(m), 16'((mag * acc) >> 15)};
    endfunction

    assign pending_count = wr_count - rd_count;

    always @(posedge aclk) begin
        if (!aresetn) begin
            mode_r <= swi_pmw_pkg::MODE_NEGATIVE;
            left_r <= -16'sd32768;
            right_r <= 16'sd32767;
            power_r <= 4'd4;
            gain_r <= 16'sd256;
            offset_r <= 16'sd0;
            fail_count <= 0;
            wr_count <= 0;
            rd_count <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    swi_pmw_pkg::REG_MASK_MODE:    mode_r <= cfg_wdata[2:0];
                    swi_pmw_pkg::REG_LEFT_CUTOFF:  left_r <= cfg_wdata;
                    swi_pmw_pkg::REG_RIGHT_CUTOFF: right_r <= cfg_wdata;
                    swi_pmw_pkg::REG_POWER_COUNT:  power_r <= cfg_wdata[3:0];
                    swi_pmw_pkg::REG_SIG_GAIN:     gain_r <= cfg_wdata;
                    swi_pmw_pkg::REG_SIG_OFFSET:   offset_r <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                expected_results[12'(wr_count)] <= weigh_voxel(s_tdata);
                wr_count <= wr_count + 1;
            end
            if (m_tvalid && m_tready) begin
                if (wr_count == rd_count) begin
                    $error("unexpected result %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin : compare
                    logic [31:0] want;
                    int errs;
                    want = expected_results[12'(rd_count)];
                    errs = 0;
                    if (want[15:0] !== m_tdata[15:0]) begin
                        $error("weighted_value expected %0d actual %0d",
                               want[15:0], m_tdata[15:0]);
                        errs++;
                    end
                    if (want[31:16] !== m_tdata[31:16]) begin
                        $error("mask_value expected %0d actual %0d",
                               want[31:16], m_tdata[31:16]);
                        errs++;
                    end
                    rd_count <= rd_count + 1;
                    fail_count <= fail_count + errs;
                end
            end
        end
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives voxels through the phase mask weighting block under a range of
// register settings and backpressure patterns; the checker judges results.
// ----------------------------------------------------------------------------
module testbench;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    int          fail_count;
    int          pending_count;
    int          send_idle = 0;
    int          recv_stall = 0;
    bit          hold_off = 1'b0;
    int          cycle_count = 0;

    localparam int CYCLE_LIMIT = 400000;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    swi_phase_mask_weight_top DUT (.*);

    swi_pmw_checker checker_inst (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL swi_phase_mask_weight_top");
            $finish;
        end
    end

    // Receiver readiness; a long hold-off keeps m_tready low on request.
    always @(negedge aclk) begin
        if (hold_off) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_voxel(logic [15:0] mag, logic [15:0] ph);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {ph, mag};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    function automatic logic [15:0] near_phase(logic signed [15:0] c);
        int v;
        v = int'(c) + $urandom_range(8) - 4;
        if ($urandom_range(3) == 0) v = $urandom_range(65535) - 32768;
        return 16'(v);
    endfunction

    initial begin : stimulus
        logic signed [15:0] lc;
        logic signed [15:0] rc;
        logic [15:0] ph;
        int modes;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: field extremes at reset settings, then each mode.
        send_voxel(16'hFFFF, 16'h8000);
        send_voxel(16'h0000, 16'h7FFF);
        send_voxel(16'hFFFF, 16'h0000);
        send_voxel(16'h1234, 16'hFFFF);
        drain();
        for (int md = 0; md < 8; md++) begin
            write_reg(swi_pmw_pkg::REG_MASK_MODE, 16'(md));
            write_reg(swi_pmw_pkg::REG_LEFT_CUTOFF, 16'hF000);
            write_reg(swi_pmw_pkg::REG_RIGHT_CUTOFF, 16'h1000);
            write_reg(swi_pmw_pkg::REG_POWER_COUNT, 16'(md == 7 ? 15 : md == 6 ? 0 : 4));
            write_reg(swi_pmw_pkg::REG_SIG_GAIN, 16'd256);
            write_reg(swi_pmw_pkg::REG_SIG_OFFSET, 16'd0);
            // Phases on and between the cutoffs, so a ramp lands exactly on zero.
            send_voxel(16'hFFFF, 16'hF000);
            send_voxel(16'hFFFF, 16'h1000);
            send_voxel(16'hFFFF, 16'h0800);
            drain();
        end

        for (int phase_no = 0; phase_no < 28; phase_no++) begin
            case (phase_no % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 87; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 87; end
                default: begin send_idle = 34; recv_stall = 34; end
            endcase
            modes = (phase_no < 20) ? phase_no % 5 : $urandom_range(7);
            lc = (phase_no == 5) ? -16'sd32768 : (phase_no == 6) ? 16'sd32767 :
                 16'($urandom_range(65535));
            rc = (phase_no == 5) ? 16'sd32767 : (phase_no == 6) ? -16'sd32768 :
                 16'($urandom_range(65535));
            if (phase_no % 3 != 2) begin
                lc = -16'($urandom_range(32767));
                rc = 16'($urandom_range(32767));
            end
            write_reg(swi_pmw_pkg::REG_MASK_MODE, 16'(modes));
            write_reg(swi_pmw_pkg::REG_LEFT_CUTOFF, lc);
            write_reg(swi_pmw_pkg::REG_RIGHT_CUTOFF, rc);
            write_reg(swi_pmw_pkg::REG_POWER_COUNT,
                      16'(phase_no == 7 ? 15 : $urandom_range(9)));
            write_reg(swi_pmw_pkg::REG_SIG_GAIN, (phase_no == 8) ? 16'h8000 :
                      (phase_no == 9) ? 16'h7FFF :
                      16'($urandom_range(65535) >> $urandom_range(15)));
            write_reg(swi_pmw_pkg::REG_SIG_OFFSET, 16'($urandom_range(65535)));
            if (phase_no == 10) begin
                hold_off = 1'b1;
                fork
                    begin repeat (300) @(negedge aclk); hold_off = 1'b0; end
                join_none
            end
            for (int n = 0; n < 62; n++) begin
                ph = near_phase((n % 2) ? lc : rc);
                send_voxel(16'($urandom_range(65535)), ph);
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("PASS swi_phase_mask_weight_top");
        end else begin
            $display("FAIL swi_phase_mask_weight_top");
        end
        $finish;
    end

endmodule
